// ===== rtl/rarmt_pkg.sv =====
`default_nettype none
package rarmt_pkg;

  localparam int LEAF_BITS = 10;
  localparam int NODE_BITS = LEAF_BITS + 1;
  localparam int LVL_BITS  = 4;
  localparam logic [NODE_BITS-1:0] ROOT_NODE = NODE_BITS'(1);
  localparam logic [NODE_BITS-1:0] LAST_NODE = {NODE_BITS{1'b1}};

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [9:0]         range_low;
    logic [9:0]         range_high;
    logic signed [31:0] delta;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] max_value;
    logic [9:0]         max_position;
    logic               found;
  } result_t;

  typedef struct packed {
    logic signed [31:0] max;
    logic [9:0]         argmax;
    logic signed [31:0] pending;
  } node_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_VISIT, S_QFOLD, S_PUSH0, S_APPLY1, S_APPLY2,
    S_RET, S_REC1, S_REC2
  } state_t;

  typedef enum logic [1:0] {
    AK_FULL, AK_LEFT, AK_RIGHT
  } apply_kind_t;

  // first leaf of heap node v at depth lvl
  function automatic logic [9:0] node_lo(logic [NODE_BITS-1:0] v,
                                         logic [LVL_BITS-1:0] lvl);
    logic [LVL_BITS-1:0]  sh;
    logic [NODE_BITS-1:0] base;
    sh   = LVL_BITS'(LEAF_BITS) - lvl;
    base = NODE_BITS'(v << sh);
    return base[9:0];
  endfunction

  // last leaf of heap node v at depth lvl
  function automatic logic [9:0] node_hi(logic [NODE_BITS-1:0] v,
                                         logic [LVL_BITS-1:0] lvl);
    logic [LVL_BITS-1:0]  sh;
    logic [NODE_BITS-1:0] mask;
    sh   = LVL_BITS'(LEAF_BITS) - lvl;
    mask = NODE_BITS'((NODE_BITS'(1) << sh) - NODE_BITS'(1));
    return node_lo(v, lvl) | mask[9:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/rarmt_alu.sv =====
`default_nettype none
module rarmt_alu
  import rarmt_pkg::*;
(
  input  wire logic signed [31:0] a,
  input  wire logic signed [31:0] b,
  output logic signed [31:0]      sum,
  output logic                    gt
);

  logic signed [32:0] wide;

  // saturating add, and a > b on the same operands
  always_comb begin
    wide = 33'(a) + 33'(b);
    if (wide > 33'sh0_7FFF_FFFF) begin
      sum = 32'sh7FFF_FFFF;
    end else if (wide < -33'sh0_8000_0000) begin
      sum = 32'sh8000_0000;
    end else begin
      sum = wide[31:0];
    end
    gt = a > b;
  end

endmodule
`default_nettype wire

// ===== rtl/rarmt_node_store.sv =====
`default_nettype none
module rarmt_node_store
  import rarmt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [NODE_BITS-1:0] waddr,
  input  wire node_t                wdata,
  input  wire logic                 re,
  input  wire logic [NODE_BITS-1:0] raddr,
  output node_t                     rdata
);

  node_t mem [2**NODE_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/range_add_range_max_tree.sv =====
// Channel | Ports                  | Handshake
// --------+------------------------+---------------------------------------
// command | cmd (cmd_t)            | beat taken when start high, busy low
// result  | result (result_t)      | beat on done, one cycle, never stalled
//
// After reset a clearing pass writes all 2047 nodes, one a cycle, busy high.
// An outside node is visited and returned from; a query folds a covered node into
// its answer and an add applies its delta; a partial node pushes any pending
// delta to both children, descends, and an add rebuilds its max on the way
// back. An empty range never raises busy; an empty query answers the next cycle.
// The result can't be stalled: catch it on the cycle done is high.
`default_nettype none
module range_add_range_max_tree
  import rarmt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  input  wire cmd_t cmd,
  output logic      done,
  output result_t   result
);

  state_t               state, state_next;
  logic [NODE_BITS-1:0] v, v_next;
  logic [LVL_BITS-1:0]  lvl, lvl_next;
  logic                 op, op_next;
  logic [9:0]           rl, rl_next, rh, rh_next;
  logic signed [31:0]   d, d_next;
  logic signed [31:0]   amt, amt_next;
  logic signed [31:0]   tmp_max, tmp_max_next;
  logic [NODE_BITS-1:0] wa, wa_next;
  apply_kind_t          akind, akind_next;
  node_t                lt, lt_next;
  logic                 acc_valid, acc_valid_next;
  logic signed [31:0]   acc_val, acc_val_next;
  logic [9:0]           acc_pos, acc_pos_next;
  result_t              result_next;
  logic                 done_next;

  logic                 we, re;
  logic [NODE_BITS-1:0] waddr, raddr;
  node_t                wdata, rd;
  logic signed [31:0]   alu_a, alu_b, alu_sum;
  logic                 alu_gt;
  logic [9:0]           nlo, nhi;
  node_t                win;

  rarmt_node_store u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rd)
  );

  rarmt_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sum (alu_sum),
    .gt  (alu_gt)
  );

  assign nlo  = node_lo(v, lvl);
  assign nhi  = node_hi(v, lvl);
  assign busy = (state != S_IDLE);
  assign win  = alu_gt ? lt : rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      v     <= ROOT_NODE;
      lvl   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      v     <= v_next;
      lvl   <= lvl_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    op        <= op_next;
    rl        <= rl_next;
    rh        <= rh_next;
    d         <= d_next;
    amt       <= amt_next;
    tmp_max   <= tmp_max_next;
    wa        <= wa_next;
    akind     <= akind_next;
    lt        <= lt_next;
    acc_valid <= acc_valid_next;
    acc_val   <= acc_val_next;
    acc_pos   <= acc_pos_next;
    result    <= result_next;
  end

  always_comb begin
    state_next     = state;
    v_next         = v;
    lvl_next       = lvl;
    op_next        = op;
    rl_next        = rl;
    rh_next        = rh;
    d_next         = d;
    amt_next       = amt;
    tmp_max_next   = tmp_max;
    wa_next        = wa;
    akind_next     = akind;
    lt_next        = lt;
    acc_valid_next = acc_valid;
    acc_val_next   = acc_val;
    acc_pos_next   = acc_pos;
    result_next    = result;
    done_next      = 1'b0;
    we             = 1'b0;
    waddr          = v;
    wdata          = '0;
    re             = 1'b0;
    raddr          = v;
    alu_a          = rd.max;
    alu_b          = amt;

    unique case (state)
      S_CLEAR: begin
        // write zero value, zero pending and the leftmost leaf
        we          = 1'b1;
        wdata       = '{max: '0, argmax: nlo, pending: '0};
        if (v == LAST_NODE) begin
          v_next     = ROOT_NODE;
          lvl_next   = '0;
          state_next = S_IDLE;
        end else begin
          v_next = NODE_BITS'(v + NODE_BITS'(1));
          if ((NODE_BITS'(v + NODE_BITS'(1)) & v) == '0) begin
            lvl_next = LVL_BITS'(lvl + LVL_BITS'(1));
          end
        end
      end

      S_IDLE: begin
        if (start) begin
          op_next        = cmd.operation;
          rl_next        = cmd.range_low;
          rh_next        = cmd.range_high;
          d_next         = cmd.delta;
          acc_valid_next = 1'b0;
          v_next         = ROOT_NODE;
          lvl_next       = '0;
          if (cmd.range_high < cmd.range_low) begin
            // empty range: drop an add, answer a query at once
            if (cmd.operation == OP_QUERY) begin
              result_next = '{max_value: -32'sd1, max_position: '0, found: 1'b0};
              done_next   = 1'b1;
            end
          end else begin
            state_next = S_VISIT;
          end
        end
      end

      S_VISIT: begin
        re = 1'b1;
        if (rl > nhi || rh < nlo) begin
          re         = 1'b0;
          state_next = S_RET;
        end else if (rl <= nlo && nhi <= rh) begin
          if (op == OP_QUERY) begin
            state_next = S_QFOLD;
          end else begin
            amt_next   = d;
            wa_next    = v;
            akind_next = AK_FULL;
            state_next = S_APPLY1;
          end
        end else begin
          state_next = S_PUSH0;
        end
      end

      S_QFOLD: begin
        // rightmost piece wins on a tie
        alu_a = acc_val;
        alu_b = rd.max;
        if (!acc_valid || !alu_gt) begin
          acc_valid_next = 1'b1;
          acc_val_next   = rd.max;
          acc_pos_next   = rd.argmax;
        end
        state_next = S_RET;
      end

      S_PUSH0: begin
        if (rd.pending == '0) begin
          v_next     = {v[NODE_BITS-2:0], 1'b0};
          lvl_next   = LVL_BITS'(lvl + LVL_BITS'(1));
          state_next = S_VISIT;
        end else begin
          we         = 1'b1;
          wdata      = '{max: rd.max, argmax: rd.argmax, pending: '0};
          amt_next   = rd.pending;
          re         = 1'b1;
          raddr      = {v[NODE_BITS-2:0], 1'b0};
          wa_next    = {v[NODE_BITS-2:0], 1'b0};
          akind_next = AK_LEFT;
          state_next = S_APPLY1;
        end
      end

      S_APPLY1: begin
        tmp_max_next = alu_sum;
        state_next   = S_APPLY2;
      end

      S_APPLY2: begin
        alu_a = rd.pending;
        we    = 1'b1;
        waddr = wa;
        wdata = '{max: tmp_max, argmax: rd.argmax, pending: alu_sum};
        unique case (akind)
          AK_FULL: state_next = S_RET;
          AK_LEFT: begin
            re         = 1'b1;
            raddr      = wa | NODE_BITS'(1);
            wa_next    = wa | NODE_BITS'(1);
            akind_next = AK_RIGHT;
            state_next = S_APPLY1;
          end
          default: begin
            v_next     = {v[NODE_BITS-2:0], 1'b0};
            lvl_next   = LVL_BITS'(lvl + LVL_BITS'(1));
            state_next = S_VISIT;
          end
        endcase
      end

      S_RET: begin
        if (v == ROOT_NODE) begin
          if (op == OP_QUERY) begin
            if (acc_valid) begin
              result_next = '{max_value: acc_val, max_position: acc_pos, found: 1'b1};
            end else begin
              result_next = '{max_value: -32'sd1, max_position: '0, found: 1'b0};
            end
            done_next   = 1'b1;
          end
          state_next = S_IDLE;
        end else if (!v[0]) begin
          v_next     = v | NODE_BITS'(1);
          state_next = S_VISIT;
        end else begin
          v_next   = v >> 1;
          lvl_next = LVL_BITS'(lvl - LVL_BITS'(1));
          if (op == OP_ADD) begin
            re         = 1'b1;
            raddr      = {v[NODE_BITS-1:1], 1'b0};
            state_next = S_REC1;
          end
        end
      end

      S_REC1: begin
        lt_next    = rd;
        re         = 1'b1;
        raddr      = {v[NODE_BITS-2:0], 1'b1};
        state_next = S_REC2;
      end

      S_REC2: begin
        // left wins only when strictly larger
        alu_a      = lt.max;
        alu_b      = rd.max;
        we         = 1'b1;
        wdata      = '{max: win.max, argmax: win.argmax, pending: '0};
        state_next = S_RET;
      end

      default: state_next = S_IDLE;
    endcase
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_add_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd.operation == OP_ADD) |=> !done)
    else $error("add produced a result");

  a_node_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_VISIT) |-> (v != '0 && lvl <= LVL_BITS'(LEAF_BITS)))
    else $error("walk left the tree");

endmodule
`default_nettype wire
